[rtl/aes256ctr_pkg.sv]
// package for the aes-256 ctr keystream block: sbox, round helpers, key expansion step
// no dependencies
`timescale 1ns / 1ps
package aes256ctr_pkg;

  localparam int unsigned NumRounds    = 14;
  localparam int unsigned NumRoundKeys = 15;
  localparam int unsigned KeyWords     = 8;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY0 = 3'd0,
    REG_KEY1 = 3'd1,
    REG_KEY2 = 3'd2,
    REG_KEY3 = 3'd3,
    REG_IVH  = 3'd4,
    REG_IVM  = 3'd5
  } cfg_reg_t;

  typedef logic [127:0] blk_t;

  // one item moving from the front queue into the cipher pipeline
  typedef struct packed {
    blk_t data;
    blk_t ctr;
    logic last;
  } item_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // byte i of a block (byte 0 in bits 127:120)
  function automatic logic [7:0] get_byte(input blk_t s, input int unsigned i);
    return s[127 - 8*i -: 8];
  endfunction

  // one cipher round; final drops mixcolumns
  function automatic blk_t aes_round(input blk_t s, input blk_t rk, input logic final_rnd);
    blk_t t;
    blk_t m;
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(r + 4*c) -: 8] = sbox(get_byte(s, r + 4*((c + r) % 4)));
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(t, 4*c);
      a1 = get_byte(t, 4*c + 1);
      a2 = get_byte(t, 4*c + 2);
      a3 = get_byte(t, 4*c + 3);
      al = a0 ^ a1 ^ a2 ^ a3;
      m[127 - 8*(4*c)     -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
      m[127 - 8*(4*c + 1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
      m[127 - 8*(4*c + 2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
      m[127 - 8*(4*c + 3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    return (final_rnd ? t : m) ^ rk;
  endfunction

  // next 128-bit round key from the previous two; odd steps use rcon, even use subword only
  function automatic blk_t key_step(input blk_t k2, input blk_t k1, input logic odd_step,
                                    input logic [7:0] rc);
    logic [31:0] w;
    logic [31:0] prev;
    blk_t o;
    w = k1[31:0];
    if (odd_step) begin
      w = {sbox(w[23:16]) ^ rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    end else begin
      w = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    end
    prev = w;
    for (int j = 0; j < 4; j++) begin
      o[127 - 32*j -: 32] = k2[127 - 32*j -: 32] ^ prev;
      prev = o[127 - 32*j -: 32];
    end
    return o;
  endfunction

endpackage

[rtl/aes256ctr_front.sv]
// front: takes items, builds the counter block, queues them for the cipher pipeline
// depends on aes256ctr_pkg
`timescale 1ns / 1ps
module aes256ctr_front #(
  parameter int unsigned DEPTH = aes256ctr_pkg::FifoDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [63:0]          iv_high,
  input  logic [31:0]          iv_middle,
  input  logic [31:0]          block_counter,
  input  logic [127:0]         data,
  input  logic                 last,
  input  logic                 take,
  output logic                 avail,
  output aes256ctr_pkg::item_t item
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  aes256ctr_pkg::item_t mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == AW'(0) + (AW+1)'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign do_push = push && !full;
  assign do_pop  = take && avail;
  assign item    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= '{data: data, ctr: {iv_high, iv_middle, block_counter}, last: last};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= (AW+1)'(DEPTH))
    else $error("front queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) (do_push && !do_pop) |=> cnt_r != '0)
    else $error("push lost");
  assert property (@(posedge clk) disable iff (!rst_n) full |-> !do_push)
    else $error("push while full");
endmodule

[rtl/aes256ctr_back.sv]
// back: key schedule registers and a 14-round pipeline, then an output queue
// depends on aes256ctr_pkg
`timescale 1ns / 1ps
module aes256ctr_back #(
  parameter int unsigned DEPTH = aes256ctr_pkg::FifoDepth
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [255:0]         key,
  input  logic                 avail,
  output logic                 take,
  input  aes256ctr_pkg::item_t item,
  output logic                 empty,
  input  logic                 pop,
  output logic [127:0]         result,
  output logic                 result_last
);
  localparam int unsigned NR  = aes256ctr_pkg::NumRounds;
  localparam int unsigned OD  = DEPTH + NR + 1;
  localparam int unsigned OAW = $clog2(OD);

  // round keys derived serially-in-space, one stage each, registered
  aes256ctr_pkg::blk_t rk_r [aes256ctr_pkg::NumRoundKeys];
  always_ff @(posedge clk) begin
    rk_r[0] <= key[255:128];
    rk_r[1] <= key[127:0];
    for (int i = 2; i < aes256ctr_pkg::NumRoundKeys; i++) begin
      rk_r[i] <= aes256ctr_pkg::key_step(rk_r[i-2], rk_r[i-1], (i % 2) == 0,
                   8'h01 << ((i / 2) - 1));
    end
  end

  // cipher pipeline: stage 0 key add, stages 1..14 rounds
  aes256ctr_pkg::blk_t st_r [NR+1];
  logic [127:0]        dat_r [NR+1];
  logic                lst_r [NR+1];
  logic [NR:0]         vld_r;

  // output queue with space reserved for everything in flight
  logic [128:0]  oq [OD];
  logic [OAW-1:0] owp_r, orp_r;
  logic [OAW:0]   ocnt_r;
  logic [OAW:0]   inflight;
  logic           opush, opop;

  always_comb begin
    inflight = '0;
    for (int i = 0; i <= NR; i++) inflight = inflight + (OAW+1)'(vld_r[i]);
  end

  assign take  = avail && ((ocnt_r + inflight) < (OAW+1)'(OD));
  assign opush = vld_r[NR];
  assign empty = (ocnt_r == '0);
  assign opop  = pop && !empty;
  assign result      = oq[orp_r][128:1];
  assign result_last = oq[orp_r][0];

  always_ff @(posedge clk) begin
    st_r[0]  <= item.ctr ^ rk_r[0];
    dat_r[0] <= item.data;
    lst_r[0] <= item.last;
    for (int i = 1; i <= NR; i++) begin
      st_r[i]  <= aes256ctr_pkg::aes_round(st_r[i-1], rk_r[i], i == NR);
      dat_r[i] <= dat_r[i-1];
      lst_r[i] <= lst_r[i-1];
    end
    if (opush) oq[owp_r] <= {st_r[NR] ^ dat_r[NR], lst_r[NR]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      owp_r  <= '0;
      orp_r  <= '0;
      ocnt_r <= '0;
    end else begin
      vld_r <= {vld_r[NR-1:0], take};
      if (opush) owp_r <= (owp_r == OAW'(OD - 1)) ? '0 : owp_r + 1'b1;
      if (opop)  orp_r <= (orp_r == OAW'(OD - 1)) ? '0 : orp_r + 1'b1;
      ocnt_r <= ocnt_r + (OAW+1)'(opush) - (OAW+1)'(opop);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) (ocnt_r + inflight) <= (OAW+1)'(OD))
    else $error("output queue overbooked");
  assert property (@(posedge clk) disable iff (!rst_n) take |-> ##(NR+1) opush)
    else $error("pipeline lost a request");
  assert property (@(posedge clk) disable iff (!rst_n) take |-> avail)
    else $error("take without item");
endmodule

[rtl/aes256_ctr_keystream_xor_top.sv]
// AES-256 CTR keystream xor: one request per cycle sustained unless full or output queue
// back-pressure stalls it; a request passes the front queue, key add, 14 round stages and
// output queue write; the pipeline sets the rate at one block per clock. Round keys come
// from a registered key schedule chain; a new key moves down the chain one stage ahead of
// the first request behind it, so requests may follow a key or iv write on the next cycle.
// depends on aes256ctr_pkg, aes256ctr_front, aes256ctr_back
`timescale 1ns / 1ps
module aes256_ctr_keystream_xor_top #(
  parameter int unsigned FIFO_DEPTH = aes256ctr_pkg::FifoDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [31:0] in_block_counter,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic        in_last_block,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low,
  output logic        out_result_last
);
  logic [63:0] key0_r, key1_r, key2_r, key3_r, ivh_r;
  logic [31:0] ivm_r;
  logic avail, take;
  aes256ctr_pkg::item_t item;
  logic [127:0] result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0; key1_r <= '0; key2_r <= '0; key3_r <= '0;
      ivh_r  <= '0; ivm_r  <= '0;
    end else if (cfg_we) begin
      case (aes256ctr_pkg::cfg_reg_t'(cfg_index))
        aes256ctr_pkg::REG_KEY0: key0_r <= cfg_data;
        aes256ctr_pkg::REG_KEY1: key1_r <= cfg_data;
        aes256ctr_pkg::REG_KEY2: key2_r <= cfg_data;
        aes256ctr_pkg::REG_KEY3: key3_r <= cfg_data;
        aes256ctr_pkg::REG_IVH:  ivh_r  <= cfg_data;
        aes256ctr_pkg::REG_IVM:  ivm_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  aes256ctr_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk, .rst_n, .push, .full,
    .iv_high(ivh_r), .iv_middle(ivm_r),
    .block_counter(in_block_counter),
    .data({in_data_high, in_data_low}),
    .last(in_last_block),
    .take, .avail, .item
  );

  aes256ctr_back #(.DEPTH(FIFO_DEPTH)) u_back (
    .clk, .rst_n,
    .key({key0_r, key1_r, key2_r, key3_r}),
    .avail, .take, .item,
    .empty, .pop, .result, .result_last(out_result_last)
  );

  assign out_result_high = result[127:64];
  assign out_result_low  = result[63:0];
endmodule

[tb/sv/aes256_ctr_keystream_xor_top_test.sv]
// self-checking test of the aes-256 ctr keystream xor block: random and directed requests,
// key and iv settings changed between phases, results checked against a local cipher model
// depends on aes256ctr_pkg and aes256_ctr_keystream_xor_top
`timescale 1ns / 1ps
module aes256_ctr_keystream_xor_top_test;

  // indexes past the last register; writes there must be dropped
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [31:0] counter;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic        last;
  } block_req_t;

  typedef struct {
    logic [63:0] high;
    logic [63:0] low;
    logic        last;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] in_block_counter = '0;
  logic [63:0] in_data_high = '0;
  logic [63:0] in_data_low = '0;
  logic        in_last_block = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [63:0] out_result_high;
  logic [63:0] out_result_low;
  logic        out_result_last;

  aes256_ctr_keystream_xor_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .in_block_counter(in_block_counter), .in_data_high(in_data_high),
    .in_data_low(in_data_low), .in_last_block(in_last_block),
    .empty(empty), .pop(pop),
    .out_result_high(out_result_high), .out_result_low(out_result_low),
    .out_result_last(out_result_last)
  );

  always #4 clk = ~clk;

  block_req_t  pending_blocks[$];
  cipher_out_t expected_blocks[$];
  int          in_idle_pct = 36;
  int          out_idle_pct = 36;
  int          error_count = 0;
  int          blocks_sent = 0;
  int          blocks_checked = 0;
  int          cycle_count = 0;

  // local copy of the registers and the derived cipher tables
  logic [63:0]  key_reg [4];
  logic [63:0]  iv_high_reg;
  logic [31:0]  iv_middle_reg;
  logic [127:0] sched_keys [15];
  logic [7:0]   sub_table [256];

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // s-box from the field inverse and the affine map
  function automatic logic [7:0] sub_byte_calc(input logic [7:0] x);
    logic [7:0] inv;
    inv = 8'h01;
    if (x == 8'h00) inv = 8'h00;
    else for (int i = 0; i < 254; i++) inv = gf_mul(inv, x);
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
           ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sub_table[w[31:24]], sub_table[w[23:16]], sub_table[w[15:8]], sub_table[w[7:0]]};
  endfunction

  task automatic expand_round_keys();
    logic [31:0] w [60];
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    for (int i = 0; i < 4; i++) begin
      w[2*i] = key_reg[i][63:32];
      w[2*i+1] = key_reg[i][31:0];
    end
    for (int i = 8; i < 60; i++) begin
      t = w[i-1];
      if (i % 8 == 0) begin
        t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = {rc[6:0], 1'b0};
      end else if (i % 8 == 4) begin
        t = sub_word(t);
      end
      w[i] = w[i-8] ^ t;
    end
    for (int r = 0; r < 15; r++) sched_keys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic cipher_out_t ctr_xor_block(input block_req_t req);
    logic [127:0] blk;
    logic [7:0]   s [16];
    logic [7:0]   t [16];
    logic [7:0]   a0, a1, a2, a3, al;
    cipher_out_t  res;
    blk = {iv_high_reg, iv_middle_reg, req.counter} ^ sched_keys[0];
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[r+4*c] = sub_table[s[r+4*((c+r)%4)]];
      for (int c = 0; c < 4; c++) begin
        if (rnd < 14) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ al ^ gf_mul(a0 ^ a1, 8'h02);
          s[4*c+1] = a1 ^ al ^ gf_mul(a1 ^ a2, 8'h02);
          s[4*c+2] = a2 ^ al ^ gf_mul(a2 ^ a3, 8'h02);
          s[4*c+3] = a3 ^ al ^ gf_mul(a3 ^ a0, 8'h02);
        end else begin
          for (int r = 0; r < 4; r++) s[4*c+r] = t[4*c+r];
        end
      end
      for (int i = 0; i < 16; i++) s[i] = s[i] ^ sched_keys[rnd][127-8*i -: 8];
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    res.high = req.data_high ^ blk[127:64];
    res.low = req.data_low ^ blk[63:0];
    res.last = req.last;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch %0s at block %0d: got %h expected %h", what, blocks_checked, got, want);
  endtask

  // request driver
  always @(posedge clk) begin
    block_req_t nxt;
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        nxt.counter = in_block_counter;
        nxt.data_high = in_data_high;
        nxt.data_low = in_data_low;
        nxt.last = in_last_block;
        expected_blocks.push_back(ctr_xor_block(nxt));
        blocks_sent++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (pending_blocks.size() > 0 && $urandom_range(99, 0) >= in_idle_pct) begin
        nxt = pending_blocks.pop_front();
        in_block_counter <= nxt.counter;
        in_data_high <= nxt.data_high;
        in_data_low <= nxt.data_low;
        in_last_block <= nxt.last;
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n && pop && !empty) begin
      if (expected_blocks.size() == 0) begin
        error_count++;
        $display("unexpected result %h %h", out_result_high, out_result_low);
      end else begin
        want = expected_blocks.pop_front();
        if (out_result_high !== want.high) report_mismatch("high", out_result_high, want.high);
        if (out_result_low !== want.low) report_mismatch("low", out_result_low, want.low);
        if (out_result_last !== want.last) begin
          report_mismatch("last", 64'(out_result_last), 64'(want.last));
        end
      end
      blocks_checked++;
    end
    pop <= rst_n && ($urandom_range(99, 0) >= out_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_blocks.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aes256ctr_pkg::REG_KEY0: key_reg[0] = value;
      aes256ctr_pkg::REG_KEY1: key_reg[1] = value;
      aes256ctr_pkg::REG_KEY2: key_reg[2] = value;
      aes256ctr_pkg::REG_KEY3: key_reg[3] = value;
      aes256ctr_pkg::REG_IVH:  iv_high_reg = value;
      aes256ctr_pkg::REG_IVM:  iv_middle_reg = value[31:0];
      default: ;
    endcase
    expand_round_keys();
  endtask

  task automatic write_all_registers(input logic [63:0] k0, input logic [63:0] k1,
                                     input logic [63:0] k2, input logic [63:0] k3,
                                     input logic [63:0] ivh, input logic [63:0] ivm);
    write_register(aes256ctr_pkg::REG_KEY0, k0);
    write_register(aes256ctr_pkg::REG_KEY1, k1);
    write_register(aes256ctr_pkg::REG_KEY2, k2);
    write_register(aes256ctr_pkg::REG_KEY3, k3);
    write_register(aes256ctr_pkg::REG_IVH, ivh);
    write_register(aes256ctr_pkg::REG_IVM, ivm);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_block(input logic [31:0] ctr, input logic [63:0] dh,
                             input logic [63:0] dl, input logic last);
    block_req_t req;
    req.counter = ctr;
    req.data_high = dh;
    req.data_low = dl;
    req.last = last;
    pending_blocks.push_back(req);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic drain_phase();
    wait (pending_blocks.size() == 0 && !push);
    wait (expected_blocks.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    logic [31:0] ctr;
    ctr = ($urandom_range(3, 0) == 0) ? 32'hffff_fff0 : $urandom;
    for (int i = 0; i < count; i++) begin
      // mostly consecutive counters as in a real stream, some arbitrary
      if ($urandom_range(9, 0) == 0) ctr = $urandom;
      queue_block(ctr, rand64(), rand64(), $urandom_range(7, 0) == 0);
      ctr = ctr + 32'd1;
    end
    drain_phase();
  endtask

  initial begin
    for (int i = 0; i < 256; i++) sub_table[i] = sub_byte_calc(i[7:0]);
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    iv_high_reg = '0;
    iv_middle_reg = '0;
    expand_round_keys();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // reset settings with field extremes
    queue_block(32'h0, 64'h0, 64'h0, 1'b0);
    queue_block(32'hffff_ffff, {64{1'b1}}, {64{1'b1}}, 1'b1);
    queue_block(32'h8000_0000, 64'h8000_0000_0000_0001, 64'h0123_4567_89ab_cdef, 1'b0);
    drain_phase();

    // all-ones key and iv, middle iv written with extra upper bits
    write_all_registers({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}},
                        {64{1'b1}});
    queue_block(32'h0, 64'h0, 64'h0, 1'b1);
    queue_block(32'hffff_ffff, {64{1'b1}}, 64'h0, 1'b0);
    queue_block(32'hffff_fffe, 64'h0, {64{1'b1}}, 1'b1);
    drain_phase();

    // writes past the last register must leave the settings alone
    write_register(REG_SPARE6, rand64());
    write_register(REG_SPARE7, rand64());
    repeat (SETTLE_CYCLES) @(posedge clk);
    queue_block(32'h1, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    queue_block(32'h7fff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
    drain_phase();

    write_all_registers(64'h0, 64'h0, 64'h0, 64'h0, 64'h0, {32'hdead_beef, 32'h0});
    random_phase(150);

    // back to back with no idling on either side
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_all_registers(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
    random_phase(250);
    in_idle_pct = 36;
    out_idle_pct = 36;

    for (int p = 0; p < 4; p++) begin
      write_all_registers(rand64(), rand64(), rand64(), rand64(), rand64(), rand64());
      random_phase(160);
    end

    $display("%0d blocks sent, %0d results checked over several key and iv settings",
             blocks_sent, blocks_checked);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
